[hw/rtl/dqrk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dqrk_pkg;

  // queue command codes
  typedef enum logic [2:0] {
    CMD_PUSH_REAR  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5,
    CMD_REMOVE     = 3'd6,
    CMD_STATUS     = 3'd7
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_t;

  localparam int HANDLE_W = 32;
  localparam int COUNT_W  = 5;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;

endpackage

`default_nettype wire

[hw/rtl/dqrk_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dqrk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/deque_with_remove_by_key_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// bounded double-ended queue of 32-bit handles with remove-by-key
//
// s_* channel: one command word per accepted transfer (command, handle).
// m_* channel: exactly one result word per command (handle, status, count).
// entries live in a single one-port-write / one-port-read ram of DEPTH words,
// addressed as a ring from head; occupancy counts the entries held.
// controller states from accept to result valid, receiver ready:
//   push and status        S_RESP straight from idle
//   pop and peek           S_READ (one ram read), then S_RESP
//   remove                 S_SEARCH, S_SHIFT if needed, then S_RESP; the
//                          search and the gap-closing shift walk the ram one
//                          word a cycle, read of offset k+1 overlapping the
//                          compare or write-back of offset k
// one command is in work at a time
// a new command is taken while an earlier result still waits in the output
// register; if the receiver stalls, the finished command parks in its
// response state until the output register frees up.
// reset clears head, occupancy, the controller and the output valid; ram
// contents are left as they are since only written cells are ever read.
module deque_with_remove_by_key_top #(
  parameter int DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // [2:0] command, [34:3] item_handle, [39:35] zero
  input  wire logic [dqrk_pkg::IN_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [31:0] out_handle, [33:32] status, [38:34] entry_count, [39] zero
  output logic      [dqrk_pkg::OUT_W-1:0]   m_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int HW = dqrk_pkg::HANDLE_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // control and pointer state
  dqrk_pkg::state_t state, state_next;
  dqrk_pkg::cmd_t   cmd_r, cmd_r_next;
  logic [HW-1:0]    key, key_next;
  logic [AW-1:0]    head, head_next;
  logic [CW-1:0]    occ, occ_next;
  logic [CW-1:0]    pos, pos_next;       // ring offset of the word now on rdata
  logic [HW-1:0]    res_handle, res_handle_next;
  dqrk_pkg::status_t res_status, res_status_next;

  // output register
  logic              out_load;
  logic [HW-1:0]     out_handle;
  dqrk_pkg::status_t out_status;
  logic [dqrk_pkg::COUNT_W-1:0] out_count;

  // ram port signals
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [HW-1:0] wdata, rdata;

  dqrk_pkg::cmd_t cmd_in;
  logic [HW-1:0]  key_in;
  logic [AW-1:0]  head_dec;
  logic [CW-1:0]  pos_inc;

  assign cmd_in   = dqrk_pkg::cmd_t'(s_tdata[2:0]);
  assign key_in   = s_tdata[HW+2:3];
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign pos_inc  = pos + CW'(1);

  // ring address of offset off from the front, one compare and subtract
  function automatic logic [AW-1:0] cell_of(input logic [AW-1:0] hd,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(hd) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  dqrk_ram #(
    .WIDTH (HW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dqrk_pkg::S_IDLE;
      head     <= '0;
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      occ   <= occ_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_r_next;
    key        <= key_next;
    pos        <= pos_next;
    res_handle <= res_handle_next;
    res_status <= res_status_next;
    if (out_load) begin
      out_handle <= res_handle;
      out_status <= res_status;
      out_count  <= dqrk_pkg::COUNT_W'(occ);
    end
  end

  assign m_tdata = {1'b0, out_count, out_status, out_handle};

  always_comb begin
    state_next      = state;
    cmd_r_next      = cmd_r;
    key_next        = key;
    head_next       = head;
    occ_next        = occ;
    pos_next        = pos;
    res_handle_next = res_handle;
    res_status_next = res_status;
    s_tready        = 1'b0;
    out_load        = 1'b0;
    we              = 1'b0;
    waddr           = head;
    wdata           = key;
    raddr           = head;

    case (state)
      dqrk_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd_r_next      = cmd_in;
          key_next        = key_in;
          res_handle_next = '0;
          res_status_next = dqrk_pkg::ST_OK;
          pos_next        = '0;
          state_next      = dqrk_pkg::S_RESP;
          case (cmd_in)
            dqrk_pkg::CMD_PUSH_REAR: begin
              if (occ == FULL_CNT) begin
                res_status_next = dqrk_pkg::ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = cell_of(head, occ);
                wdata    = key_in;
                occ_next = occ + CW'(1);
              end
            end
            dqrk_pkg::CMD_PUSH_FRONT: begin
              if (occ == FULL_CNT) begin
                res_status_next = dqrk_pkg::ST_FULL;
              end else begin
                we        = 1'b1;
                waddr     = head_dec;
                wdata     = key_in;
                head_next = head_dec;
                occ_next  = occ + CW'(1);
              end
            end
            dqrk_pkg::CMD_POP_FRONT, dqrk_pkg::CMD_PEEK_FRONT: begin
              if (occ == '0) begin
                res_status_next = dqrk_pkg::ST_EMPTY;
              end else begin
                raddr      = head;
                state_next = dqrk_pkg::S_READ;
              end
            end
            dqrk_pkg::CMD_POP_REAR, dqrk_pkg::CMD_PEEK_REAR: begin
              if (occ == '0) begin
                res_status_next = dqrk_pkg::ST_EMPTY;
              end else begin
                raddr      = cell_of(head, occ - CW'(1));
                state_next = dqrk_pkg::S_READ;
              end
            end
            dqrk_pkg::CMD_REMOVE: begin
              if (occ == '0) begin
                res_status_next = dqrk_pkg::ST_NOT_FOUND;
              end else begin
                raddr      = head;
                state_next = dqrk_pkg::S_SEARCH;
              end
            end
            default: begin
              // status query answers with the count only
            end
          endcase
        end
      end

      dqrk_pkg::S_READ: begin
        res_handle_next = rdata;
        if (cmd_r == dqrk_pkg::CMD_POP_FRONT) begin
          head_next = cell_of(head, CW'(1));
          occ_next  = occ - CW'(1);
        end else if (cmd_r == dqrk_pkg::CMD_POP_REAR) begin
          occ_next = occ - CW'(1);
        end
        state_next = dqrk_pkg::S_RESP;
      end

      dqrk_pkg::S_SEARCH: begin
        // compare word at pos, fetch pos+1 in the same cycle
        raddr = cell_of(head, pos_inc);
        if (rdata == key) begin
          if (pos_inc < occ) begin
            pos_next   = pos_inc;
            state_next = dqrk_pkg::S_SHIFT;
          end else begin
            occ_next   = occ - CW'(1);
            state_next = dqrk_pkg::S_RESP;
          end
        end else if (pos_inc < occ) begin
          pos_next = pos_inc;
        end else begin
          res_status_next = dqrk_pkg::ST_NOT_FOUND;
          state_next      = dqrk_pkg::S_RESP;
        end
      end

      dqrk_pkg::S_SHIFT: begin
        // move word at pos down one slot, fetch pos+1
        we    = 1'b1;
        waddr = cell_of(head, pos - CW'(1));
        wdata = rdata;
        raddr = cell_of(head, pos_inc);
        if (pos_inc < occ) begin
          pos_next = pos_inc;
        end else begin
          occ_next   = occ - CW'(1);
          state_next = dqrk_pkg::S_RESP;
        end
      end

      dqrk_pkg::S_RESP: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = dqrk_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = dqrk_pkg::S_IDLE;
      end
    endcase
  end

  // occupancy never passes the ring size
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= FULL_CNT)
    else $error("occupancy above depth");

  // a push onto a full queue leaves the count alone
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && occ == FULL_CNT &&
     (cmd_in == dqrk_pkg::CMD_PUSH_REAR || cmd_in == dqrk_pkg::CMD_PUSH_FRONT))
    |=> $stable(occ))
    else $error("push on full queue changed occupancy");

  // a pop from the front of a nonempty queue takes exactly one entry
  a_pop_front: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && occ != '0 && cmd_in == dqrk_pkg::CMD_POP_FRONT)
    |=> ##1 (occ == $past(occ, 2) - CW'(1)))
    else $error("pop front did not drop one entry");

  // the shift walk stays inside the held entries and past the front
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == dqrk_pkg::S_SHIFT) |-> (pos != '0 && pos < occ))
    else $error("shift position out of range");

endmodule

`default_nettype wire
